/* sv/lant_pkg.sv */
package lant_pkg;

	// Grid geometry
	localparam int GRID_SIDE = 64;
	localparam int COORD_W   = 6;
	localparam int ROW_W     = $clog2(GRID_SIDE);
	localparam int SIDE_W    = 7;
	localparam int HEAD_W    = 2;
	localparam int OP_W      = 2;
	localparam int TURN_W    = 2;

	// APB register map
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_MAP_SIDE  = 2'd0,
		REG_WRAP_MODE = 2'd1,
		REG_TURN_RULE = 2'd2
	} reg_idx_t;

	// Request opcodes
	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_PLACE = 2'd1,
		OP_LOAD  = 2'd2
	} op_t;

	// Headings
	localparam logic [HEAD_W-1:0] HD_NORTH = 2'd0;
	localparam logic [HEAD_W-1:0] HD_EAST  = 2'd1;
	localparam logic [HEAD_W-1:0] HD_SOUTH = 2'd2;
	localparam logic [HEAD_W-1:0] HD_WEST  = 2'd3;

	// Register reset values
	localparam logic [SIDE_W-1:0] MAP_SIDE_RST  = SIDE_W'(GRID_SIDE);
	localparam logic              WRAP_MODE_RST = 1'b0;
	localparam logic [TURN_W-1:0] TURN_RULE_RST = 2'd1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

endpackage

/* sv/lant_ifs.sv */
interface lant_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [lant_pkg::OP_W-1:0]    op;
	logic [lant_pkg::COORD_W-1:0] coord_x;
	logic [lant_pkg::COORD_W-1:0] coord_y;
	logic [lant_pkg::HEAD_W-1:0]  start_heading;
	logic                         cell_colour;

	modport source (
		output valid, op, coord_x, coord_y, start_heading, cell_colour,
		input  ready
	);
	modport sink (
		input  valid, op, coord_x, coord_y, start_heading, cell_colour,
		output ready
	);
endinterface

interface lant_res_if;
	logic                         valid;
	logic                         ready;
	logic                         moved;
	logic [lant_pkg::COORD_W-1:0] pos_x;
	logic [lant_pkg::COORD_W-1:0] pos_y;
	logic [lant_pkg::HEAD_W-1:0]  heading;
	logic                         alive;
	logic                         painted;

	modport source (
		output valid, moved, pos_x, pos_y, heading, alive, painted,
		input  ready
	);
	modport sink (
		input  valid, moved, pos_x, pos_y, heading, alive, painted,
		output ready
	);
endinterface

/* sv/lant_ram.sv */
module lant_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/langton_ant_step_core.sv */
// The grid row RAM is read on the accepting edge; the turn, step and write-back finish
// and the result is registered once the result slot is free. Requests do not overlap:
// a new one is taken only then, even while a finished result waits in the output register.
// Reset (arst_n low, async): ant at (0,0) heading north and alive, registers to defaults.
// Grid rows carry valid flops cleared by reset, so the whole grid reads white at once;
// no clearing pass is run.
module langton_ant_step_core (
	input  logic                           clk,
	input  logic                           arst_n,
	lant_cmd_if.sink                       cmd,
	lant_res_if.source                     res,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lant_pkg::PADDR_W-1:0]   paddr,
	input  logic [lant_pkg::PDATA_W-1:0]   pwdata,
	output logic [lant_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	localparam int CW = lant_pkg::COORD_W;
	localparam int SW = lant_pkg::SIDE_W;
	localparam int GS = lant_pkg::GRID_SIDE;
	localparam logic [SW-1:0] SIDE_MAX = SW'(GS);

	lant_pkg::state_t state_q;

	// Config registers
	logic [SW-1:0]               map_side_q;
	logic                        wrap_mode_q;
	logic [lant_pkg::TURN_W-1:0] turn_rule_q;

	// Ant state
	logic [CW-1:0]               ant_x_q, ant_y_q;
	logic [lant_pkg::HEAD_W-1:0] ant_heading_q;
	logic                        ant_alive_q;

	// Per-row valid bits: an unwritten row reads white
	logic [GS-1:0] row_valid_q;

	// Request held for the execute cycle
	logic [lant_pkg::OP_W-1:0]   op_s1;
	logic [CW-1:0]               cx_s1, cy_s1;
	logic [lant_pkg::HEAD_W-1:0] hd_s1;
	logic                        col_s1;
	logic                        rvalid_s1;

	// Result register
	logic                        res_valid_q;
	logic                        moved_q, alive_q, painted_q;
	logic [CW-1:0]               pos_x_q, pos_y_q;
	logic [lant_pkg::HEAD_W-1:0] heading_q;

	logic                        cfg_wr, acc, done;
	logic [lant_pkg::ROW_W-1:0]  rd_row, wr_row;
	logic [GS-1:0]               ram_rdata, row_data, wr_data;
	logic                        wr_en;

	logic [SW-1:0]               side;
	logic                        cur_colour, turn_right;
	logic [lant_pkg::HEAD_W-1:0] turned_hd;
	logic [SW:0]                 nx, ny;
	logic                        x_under, x_over, y_under, y_over;
	logic [CW-1:0]               wrap_x, wrap_y;

	logic                        nxt_moved, nxt_alive, nxt_painted;
	logic [CW-1:0]               nxt_x, nxt_y;
	logic [lant_pkg::HEAD_W-1:0] nxt_hd;

	// APB register port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_side_q  <= lant_pkg::MAP_SIDE_RST;
			wrap_mode_q <= lant_pkg::WRAP_MODE_RST;
			turn_rule_q <= lant_pkg::TURN_RULE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				lant_pkg::REG_MAP_SIDE:  map_side_q  <= pwdata[SW-1:0];
				lant_pkg::REG_WRAP_MODE: wrap_mode_q <= pwdata[0];
				lant_pkg::REG_TURN_RULE: turn_rule_q <= pwdata[lant_pkg::TURN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			lant_pkg::REG_MAP_SIDE:  prdata = lant_pkg::PDATA_W'(map_side_q);
			lant_pkg::REG_WRAP_MODE: prdata = lant_pkg::PDATA_W'(wrap_mode_q);
			lant_pkg::REG_TURN_RULE: prdata = lant_pkg::PDATA_W'(turn_rule_q);
			default:                 prdata = '0;
		endcase
	end

	// Handshake: issue the row read on accept, finish when the result slot frees
	assign cmd.ready = (state_q == lant_pkg::ST_IDLE);
	assign acc       = cmd.valid & cmd.ready;
	assign done      = (state_q == lant_pkg::ST_EXEC) & (~res_valid_q | res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lant_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				lant_pkg::ST_IDLE: if (acc)  state_q <= lant_pkg::ST_EXEC;
				lant_pkg::ST_EXEC: if (done) state_q <= lant_pkg::ST_IDLE;
				default:                     state_q <= lant_pkg::ST_IDLE;
			endcase
		end
	end

	assign rd_row = (cmd.op == lant_pkg::OP_TICK) ? ant_y_q : cmd.coord_y;

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1     <= cmd.op;
			cx_s1     <= cmd.coord_x;
			cy_s1     <= cmd.coord_y;
			hd_s1     <= cmd.start_heading;
			col_s1    <= cmd.cell_colour;
			rvalid_s1 <= row_valid_q[rd_row];
		end
	end

	// Grid storage: one row of cells per word
	lant_ram #(
		.WIDTH (GS),
		.DEPTH (GS)
	) u_grid (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_row),
		.wdata (wr_data),
		.re    (acc),
		.raddr (rd_row),
		.rdata (ram_rdata)
	);

	assign row_data = rvalid_s1 ? ram_rdata : '0;

	// Effective map side, clamped to 1..GRID_SIDE
	always_comb begin
		if (map_side_q == '0) begin
			side = SW'(1);
		end else if (map_side_q > SIDE_MAX) begin
			side = SIDE_MAX;
		end else begin
			side = map_side_q;
		end
	end

	// Turn and step
	assign cur_colour = row_data[ant_x_q];
	assign turn_right = turn_rule_q[cur_colour];
	assign turned_hd  = turn_right ? ant_heading_q + 2'd1 : ant_heading_q - 2'd1;

	always_comb begin
		nx = {2'b00, ant_x_q};
		ny = {2'b00, ant_y_q};
		case (turned_hd)
			lant_pkg::HD_NORTH: ny = {2'b00, ant_y_q} - (SW+1)'(1);
			lant_pkg::HD_EAST:  nx = {2'b00, ant_x_q} + (SW+1)'(1);
			lant_pkg::HD_SOUTH: ny = {2'b00, ant_y_q} + (SW+1)'(1);
			default:            nx = {2'b00, ant_x_q} - (SW+1)'(1);
		endcase
	end

	// The top bit flags a step below zero
	assign x_under = nx[SW];
	assign y_under = ny[SW];
	assign x_over  = ~nx[SW] & (nx[SW-1:0] >= side);
	assign y_over  = ~ny[SW] & (ny[SW-1:0] >= side);

	always_comb begin
		if (x_under) begin
			wrap_x = CW'(side - SW'(1));
		end else if (x_over) begin
			wrap_x = '0;
		end else begin
			wrap_x = nx[CW-1:0];
		end
		if (y_under) begin
			wrap_y = CW'(side - SW'(1));
		end else if (y_over) begin
			wrap_y = '0;
		end else begin
			wrap_y = ny[CW-1:0];
		end
	end

	// Next ant state, result and grid write
	always_comb begin
		nxt_x       = ant_x_q;
		nxt_y       = ant_y_q;
		nxt_hd      = ant_heading_q;
		nxt_alive   = ant_alive_q;
		nxt_moved   = 1'b0;
		nxt_painted = 1'b0;
		wr_en       = 1'b0;
		wr_row      = cy_s1;
		wr_data     = row_data;
		case (op_s1)
			lant_pkg::OP_TICK: begin
				if (ant_alive_q) begin
					nxt_hd           = turned_hd;
					nxt_painted      = turn_right;
					wr_en            = done;
					wr_row           = ant_y_q;
					wr_data[ant_x_q] = turn_right;
					if (x_under | x_over | y_under | y_over) begin
						if (wrap_mode_q) begin
							nxt_x     = wrap_x;
							nxt_y     = wrap_y;
							nxt_moved = 1'b1;
						end else begin
							nxt_alive = 1'b0;
						end
					end else begin
						nxt_x     = nx[CW-1:0];
						nxt_y     = ny[CW-1:0];
						nxt_moved = 1'b1;
					end
				end
			end
			lant_pkg::OP_PLACE: begin
				nxt_x     = ({1'b0, cx_s1} >= SIDE_MAX) ? CW'(GS - 1) : cx_s1;
				nxt_y     = ({1'b0, cy_s1} >= SIDE_MAX) ? CW'(GS - 1) : cy_s1;
				nxt_hd    = hd_s1;
				nxt_alive = 1'b1;
			end
			lant_pkg::OP_LOAD: begin
				if (({1'b0, cx_s1} < SIDE_MAX) && ({1'b0, cy_s1} < SIDE_MAX)) begin
					wr_en          = done;
					wr_data[cx_s1] = col_s1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ant_x_q       <= '0;
			ant_y_q       <= '0;
			ant_heading_q <= lant_pkg::HD_NORTH;
			ant_alive_q   <= 1'b1;
			row_valid_q   <= '0;
		end else if (done) begin
			ant_x_q       <= nxt_x;
			ant_y_q       <= nxt_y;
			ant_heading_q <= nxt_hd;
			ant_alive_q   <= nxt_alive;
			if (wr_en) begin
				row_valid_q[wr_row] <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			moved_q   <= nxt_moved;
			pos_x_q   <= nxt_x;
			pos_y_q   <= nxt_y;
			heading_q <= nxt_hd;
			alive_q   <= nxt_alive;
			painted_q <= nxt_painted;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.moved   = moved_q;
	assign res.pos_x   = pos_x_q;
	assign res.pos_y   = pos_y_q;
	assign res.heading = heading_q;
	assign res.alive   = alive_q;
	assign res.painted = painted_q;

endmodule

/* tb/langton_ant_step_core_chk.sv */
module langton_ant_step_core_chk
	import lant_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	lant_cmd_if                cmd,
	lant_res_if                res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 n_fail,
	output int                 n_wait
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               moved;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [HEAD_W-1:0]  heading;
		logic               alive;
		logic               painted;
	} ant_report_t;

	// Shadow copy of the grid, the ant and the registers
	logic               grid_bits [GRID_SIDE*GRID_SIDE];
	logic [COORD_W-1:0] ant_x;
	logic [COORD_W-1:0] ant_y;
	logic [HEAD_W-1:0]  ant_hd;
	logic               ant_live;
	logic [SIDE_W-1:0]  side_reg;
	logic               wrap_reg;
	logic [TURN_W-1:0]  rule_reg;

	ant_report_t expected_reports [$];

	// Apply one request to the shadow state and return the report it should produce
	function automatic ant_report_t step_ant(
		input logic [OP_W-1:0]    op,
		input logic [COORD_W-1:0] cx,
		input logic [COORD_W-1:0] cy,
		input logic [HEAD_W-1:0]  hd,
		input logic               colour
	);
		ant_report_t rep;
		int          side;
		int          nx;
		int          ny;
		int          idx;
		logic        turn_right;
		rep = '0;
		case (op)
		OP_TICK: begin
			// a dead ant ignores ticks
			if (ant_live) begin
				side = (side_reg == 0) ? 1 :
				       ((side_reg > GRID_SIDE) ? GRID_SIDE : int'(side_reg));
				idx = int'(ant_y) * GRID_SIDE + int'(ant_x);
				turn_right = rule_reg[grid_bits[idx]];
				rep.painted = turn_right;
				grid_bits[idx] = turn_right;
				ant_hd = turn_right ? HEAD_W'(ant_hd + 1) : HEAD_W'(ant_hd - 1);
				nx = int'(ant_x);
				ny = int'(ant_y);
				case (ant_hd)
				HD_NORTH: ny--;
				HD_EAST:  nx++;
				HD_SOUTH: ny++;
				default:  nx--;
				endcase
				// off the map (also catches an ant outside a shrunk map)
				if (nx < 0 || ny < 0 || nx >= side || ny >= side) begin
					if (wrap_reg) begin
						if (nx < 0)
							nx = side - 1;
						else if (nx >= side)
							nx = 0;
						if (ny < 0)
							ny = side - 1;
						else if (ny >= side)
							ny = 0;
						ant_x = COORD_W'(nx);
						ant_y = COORD_W'(ny);
						rep.moved = 1'b1;
					end else begin
						ant_live = 1'b0;
					end
				end else begin
					ant_x = COORD_W'(nx);
					ant_y = COORD_W'(ny);
					rep.moved = 1'b1;
				end
			end
		end
		OP_PLACE: begin
			// 6-bit coordinates never exceed the grid, so no saturation applies
			ant_x = cx;
			ant_y = cy;
			ant_hd = hd;
			ant_live = 1'b1;
		end
		OP_LOAD: begin
			grid_bits[int'(cy) * GRID_SIDE + int'(cx)] = colour;
		end
		default: ;
		endcase
		rep.pos_x = ant_x;
		rep.pos_y = ant_y;
		rep.heading = ant_hd;
		rep.alive = ant_live;
		return rep;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
	                                    input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			n_fail++;
		end
	endfunction

	// Track config writes, predict on each request, compare on each result
	always @(posedge clk or negedge arst_n) begin
		ant_report_t want;
		if (!arst_n) begin
			foreach (grid_bits[i])
				grid_bits[i] = 1'b0;
			ant_x = '0;
			ant_y = '0;
			ant_hd = HD_NORTH;
			ant_live = 1'b1;
			side_reg = MAP_SIDE_RST;
			wrap_reg = WRAP_MODE_RST;
			rule_reg = TURN_RULE_RST;
			expected_reports.delete();
			n_fail = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_reports.size() == 0) begin
					$error("result with no request outstanding");
					n_fail++;
				end else begin
					want = expected_reports.pop_front();
					check_field("moved", 8'(want.moved), 8'(res.moved));
					check_field("pos_x", 8'(want.pos_x), 8'(res.pos_x));
					check_field("pos_y", 8'(want.pos_y), 8'(res.pos_y));
					check_field("heading", 8'(want.heading), 8'(res.heading));
					check_field("alive", 8'(want.alive), 8'(res.alive));
					check_field("painted", 8'(want.painted), 8'(res.painted));
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
				REG_MAP_SIDE:  side_reg = pwdata[SIDE_W-1:0];
				REG_WRAP_MODE: wrap_reg = pwdata[0];
				REG_TURN_RULE: rule_reg = pwdata[TURN_W-1:0];
				default: ;
				endcase
			end
			if (cmd.valid && cmd.ready)
				expected_reports.push_back(step_ant(cmd.op, cmd.coord_x, cmd.coord_y,
				                                    cmd.start_heading, cmd.cell_colour));
		end
		n_wait = expected_reports.size();
	end

endmodule

/* tb/langton_ant_step_core_tb.sv */
module langton_ant_step_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lant_pkg::*;

	// unused opcode: the block must just report the ant
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int RANDOM_ITEMS   = 2000;
	localparam int PHASES         = 8;
	localparam int WATCHDOG_LIMIT = 4000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int n_fail;
	int n_wait;
	int burst_left = 0;
	int ready_left = 0;
	int quiet_cycles = 0;
	bit ready_phase = 1'b0;
	bit no_idle = 1'b0;

	lant_cmd_if cmd_ch ();
	lant_res_if res_ch ();

	langton_ant_step_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	langton_ant_step_core_chk u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.n_fail  (n_fail),
		.n_wait  (n_wait)
	);

	always #1 clk = ~clk;

	// Result backpressure: alternating ready and stall runs of random length, or ready held high in no-idle phases
	always @(negedge clk) begin
		if (no_idle) begin
			res_ch.ready <= 1'b1;
		end else begin
			if (ready_left == 0) begin
				ready_phase = !ready_phase;
				ready_left = ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 5);
			end
			ready_left--;
			res_ch.ready <= ready_phase;
		end
	end

	// Watchdog on cycles with no handshake of any kind
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
		    (psel && penable && pwrite)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// APB write, setup then access; called on a falling edge
	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drain outstanding requests, then reprogram all three registers
	task automatic set_mode(input logic [SIDE_W-1:0] side, input logic wrap,
	                        input logic [TURN_W-1:0] rule);
		cmd_ch.valid <= 1'b0;
		while (n_wait != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(REG_MAP_SIDE, PDATA_W'(side));
		write_reg(REG_WRAP_MODE, PDATA_W'(wrap));
		write_reg(REG_TURN_RULE, PDATA_W'(rule));
		burst_left = 0;
	endtask

	// One request; bursts of random length with random gaps in between
	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] cx,
	                        input logic [COORD_W-1:0] cy, input logic [HEAD_W-1:0] hd,
	                        input logic colour);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = no_idle ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.op <= op;
		cmd_ch.coord_x <= cx;
		cmd_ch.coord_y <= cy;
		cmd_ch.start_heading <= hd;
		cmd_ch.cell_colour <= colour;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	// Mostly ticks; places revive the ant, loads seed the map
	task automatic send_random(input int side);
		int                 pick;
		logic [OP_W-1:0]    op;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0) begin
			cx = COORD_W'($urandom_range(0, GRID_SIDE - 1));
			cy = COORD_W'($urandom_range(0, GRID_SIDE - 1));
		end else begin
			cx = COORD_W'($urandom_range(0, side - 1));
			cy = COORD_W'($urandom_range(0, side - 1));
		end
		if (pick < 68)
			op = OP_TICK;
		else if (pick < 80)
			op = OP_PLACE;
		else if (pick < 96)
			op = OP_LOAD;
		else
			op = OP_SPARE;
		send_cmd(op, cx, cy, HEAD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		logic [SIDE_W-1:0] side_raw;
		logic              wrap;
		logic [TURN_W-1:0] rule;
		int                eff_side;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = OP_TICK;
		cmd_ch.coord_x = '0;
		cmd_ch.coord_y = '0;
		cmd_ch.start_heading = HD_NORTH;
		cmd_ch.cell_colour = 1'b0;
		res_ch.ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: full map, kill at edges, right on white / left on black
		send_cmd(OP_TICK, '0, '0, HD_NORTH, 1'b0);
		send_cmd(OP_TICK, '0, '0, HD_NORTH, 1'b0);
		send_cmd(OP_PLACE, 6'd63, 6'd63, HD_EAST, 1'b0);
		send_cmd(OP_TICK, '0, '0, HD_NORTH, 1'b0);      // falls off the bottom edge
		send_cmd(OP_TICK, '0, '0, HD_NORTH, 1'b0);      // dead ant
		send_cmd(OP_SPARE, 6'd63, 6'd63, HD_WEST, 1'b1);
		send_cmd(OP_LOAD, '0, '0, HD_NORTH, 1'b1);
		send_cmd(OP_LOAD, 6'd63, 6'd63, HD_NORTH, 1'b1);
		send_cmd(OP_PLACE, '0, '0, HD_WEST, 1'b0);
		send_cmd(OP_TICK, '0, '0, HD_NORTH, 1'b0);      // black cell, left turn
		send_cmd(OP_LOAD, '0, '0, HD_NORTH, 1'b0);
		send_cmd(OP_PLACE, '0, '0, HD_WEST, 1'b0);
		send_cmd(OP_TICK, '0, '0, HD_NORTH, 1'b0);      // off the top edge

		// Side zero acts as one; torus of a single cell
		set_mode(7'd0, 1'b1, 2'd3);
		send_cmd(OP_PLACE, '0, '0, HD_NORTH, 1'b0);
		send_cmd(OP_TICK, '0, '0, HD_NORTH, 1'b0);
		send_cmd(OP_TICK, '0, '0, HD_NORTH, 1'b0);
		send_cmd(OP_PLACE, 6'd40, 6'd40, HD_SOUTH, 1'b0);
		send_cmd(OP_TICK, '0, '0, HD_NORTH, 1'b0);      // outside shrunk map, wraps

		// Small map, always turn left, kill mode
		set_mode(7'd8, 1'b0, 2'd0);
		send_cmd(OP_PLACE, 6'd7, 6'd7, HD_EAST, 1'b0);
		send_cmd(OP_TICK, '0, '0, HD_NORTH, 1'b0);
		send_cmd(OP_PLACE, 6'd40, 6'd40, HD_NORTH, 1'b0);
		send_cmd(OP_TICK, '0, '0, HD_NORTH, 1'b0);      // outside shrunk map, dies

		// Random phases; first ones pin the register extremes
		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: side_raw = 7'd127;
			1: side_raw = 7'd0;
			2: side_raw = 7'd1;
			3: side_raw = 7'd64;
			default: side_raw = SIDE_W'(($urandom_range(0, 1) == 0) ? $urandom_range(2, 16)
			                                                        : $urandom_range(0, 127));
			endcase
			wrap = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
			rule = (p < 4) ? p[TURN_W-1:0] : TURN_W'($urandom_range(0, 3));
			set_mode(side_raw, wrap, rule);
			no_idle = ($urandom_range(0, 3) == 0);
			eff_side = (side_raw == 0) ? 1 :
			           ((side_raw > GRID_SIDE) ? GRID_SIDE : int'(side_raw));
			send_cmd(OP_PLACE, COORD_W'($urandom_range(0, eff_side - 1)),
			         COORD_W'($urandom_range(0, eff_side - 1)),
			         HEAD_W'($urandom_range(0, 3)), 1'b0);
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
				send_random(eff_side);
		end

		// Drain and give the verdict
		cmd_ch.valid <= 1'b0;
		while (n_wait != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (n_fail == 0 && n_wait == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
sv/lant_pkg.sv
sv/lant_ifs.sv
sv/lant_ram.sv
sv/langton_ant_step_core.sv
tb/langton_ant_step_core_chk.sv
tb/langton_ant_step_core_tb.sv
